// ----- hw/rtl/rot2_pkg.sv -----
// rot2_pkg: shared constants for the symmetric 2x2 rotation core.
// No dependencies; used by the channel interfaces, the core and its checker.
package rot2_pkg;

  // Default data format: signed Q15.16 data, Q1.16 coefficients
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Number of register stages from request to result
  localparam int PIPE_STAGES = 6;

endpackage

// ----- hw/rtl/rot2_req_if.sv -----
// rot2_req_if: request channel of the rotation core (matrix, rotation, last flag).
// Depends on rot2_pkg for default widths.
interface rot2_req_if #(
  parameter int DATA_WIDTH = rot2_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = rot2_pkg::FRAC_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [DATA_WIDTH-1:0]  x_in;
  logic signed [DATA_WIDTH-1:0]  y_in;
  logic signed [DATA_WIDTH-1:0]  z_in;
  logic signed [FRAC_BITS+1:0]   cos_in;
  logic signed [FRAC_BITS+1:0]   sin_in;
  logic                          last_in;

  modport source (output valid, x_in, y_in, z_in, cos_in, sin_in, last_in, input ready);
  modport sink   (input valid, x_in, y_in, z_in, cos_in, sin_in, last_in, output ready);
endinterface

// ----- hw/rtl/rot2_res_if.sv -----
// rot2_res_if: result channel of the rotation core (rotated x, y, z, last flag).
// Depends on rot2_pkg for default widths.
interface rot2_res_if #(
  parameter int DATA_WIDTH = rot2_pkg::DATA_WIDTH_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [DATA_WIDTH-1:0]  x_out;
  logic signed [DATA_WIDTH-1:0]  y_out;
  logic signed [DATA_WIDTH-1:0]  z_out;
  logic                          last_out;

  modport source (output valid, x_out, y_out, z_out, last_out, input ready);
  modport sink   (input valid, x_out, y_out, z_out, last_out, output ready);
endinterface

// ----- hw/rtl/symmetric_2x2_rotation_apply_core.sv -----
// Two-sided plane rotation of a symmetric 2x2 matrix [x z; z y], fixed point.
// Depends on rot2_pkg, rot2_req_if and rot2_res_if.
//
// Usage:
//   req carries one request per handshake: x, y, z (signed, FRAC_BITS fraction
//   bits), cosine and sine (signed Q1.FRAC_BITS) and a last flag. res returns
//   one result per request, in order: rotated x, y, z, rounded half up once
//   and saturated to DATA_WIDTH bits, and the last flag copied through.
//   Throughput is one request per cycle while res is not stalled: six register
//   stages (first products, rotation terms, split second products, product
//   merge, sums with rounding, saturation into the output register).
//   Each stage has its own valid bit and advances when it is empty or the
//   stage after it advances, so bubbles close up and req.ready stays high
//   while the output register waits, as long as an earlier stage is free.
//   A stall on res holds every full stage; nothing is dropped or repeated.
//   Synchronous reset clears all valid bits; data registers are not reset.
module symmetric_2x2_rotation_apply_core #(
  parameter int DATA_WIDTH = rot2_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = rot2_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  rot2_req_if.sink       req,
  rot2_res_if.source     res
);

  localparam int CW   = FRAC_BITS + 2;        // coefficient width
  localparam int P1W  = DATA_WIDTH + CW;      // first product width
  localparam int TW   = P1W + 1;              // rotation term width
  localparam int LO_W = TW / 2;               // low split of a term
  localparam int HI_W = TW - LO_W;            // high split of a term
  localparam int PLW  = CW + LO_W + 1;        // partial product, low half
  localparam int PHW  = CW + HI_W;            // partial product, high half
  localparam int PW   = CW + TW;              // full second product width
  localparam int RSW  = PW + 2;               // sum plus rounding headroom
  localparam int SH   = 2 * FRAC_BITS;

  localparam logic signed [RSW-1:0] HALF =
    {{(RSW-SH){1'b0}}, 1'b1, {(SH-1){1'b0}}};
  localparam logic signed [RSW-1:0] MAXV =
    {{(RSW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [RSW-1:0] MINV =
    {{(RSW-DATA_WIDTH+1){1'b1}}, {(DATA_WIDTH-1){1'b0}}};

  // Round has already been added; drop the fraction and clamp
  function automatic logic signed [DATA_WIDTH-1:0] sat(input logic signed [RSW-1:0] v);
    logic signed [RSW-1:0] sh;
    sh = v >>> SH;
    if (sh > MAXV) begin
      sat = MAXV[DATA_WIDTH-1:0];
    end else if (sh < MINV) begin
      sat = MINV[DATA_WIDTH-1:0];
    end else begin
      sat = sh[DATA_WIDTH-1:0];
    end
  endfunction

  // Stage valid bits and advance enables
  logic v1, v2, v3, v4, v5, v6;
  logic e1, e2, e3, e4, e5, e6;

  assign e6 = !v6 || res.ready;
  assign e5 = !v5 || e6;
  assign e4 = !v4 || e5;
  assign e3 = !v3 || e4;
  assign e2 = !v2 || e3;
  assign e1 = !v1 || e2;
  assign req.ready = e1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (e1) v1 <= req.valid;
      if (e2) v2 <= v1;
      if (e3) v3 <= v2;
      if (e4) v4 <= v3;
      if (e5) v5 <= v4;
      if (e6) v6 <= v5;
    end
  end

  // Stage 1: six coefficient-by-data products
  logic signed [CW-1:0]  c1, s1;
  logic                  l1;
  logic signed [P1W-1:0] sz1, cz1, sx1, sy1, cx1, cy1;

  always_ff @(posedge clk) begin
    if (e1) begin
      c1  <= req.cos_in;
      s1  <= req.sin_in;
      l1  <= req.last_in;
      sz1 <= P1W'(req.sin_in) * P1W'(req.z_in);
      cz1 <= P1W'(req.cos_in) * P1W'(req.z_in);
      sx1 <= P1W'(req.sin_in) * P1W'(req.x_in);
      sy1 <= P1W'(req.sin_in) * P1W'(req.y_in);
      cx1 <= P1W'(req.cos_in) * P1W'(req.x_in);
      cy1 <= P1W'(req.cos_in) * P1W'(req.y_in);
    end
  end

  // Stage 2: rotation terms t3..t6
  logic signed [CW-1:0] c2, s2;
  logic                 l2;
  logic signed [TW-1:0] t3, t4, t5, t6;

  always_ff @(posedge clk) begin
    if (e2) begin
      c2 <= c1;
      s2 <= s1;
      l2 <= l1;
      t3 <= TW'(cz1) - TW'(sx1);
      t4 <= TW'(cz1) + TW'(sy1);
      t5 <= TW'(cx1) + TW'(sz1);
      t6 <= TW'(cy1) - TW'(sz1);
    end
  end

  // Stage 3: second products, each term split in a high and a low half.
  // Order: c*t5, s*t4, c*t6, s*t3, c*t4, s*t5
  logic signed [CW-1:0]   mc [6];
  logic signed [TW-1:0]   mt [6];
  logic signed [PLW-1:0]  pp_lo [6];
  logic signed [PHW-1:0]  pp_hi [6];
  logic                   l3;

  always_comb begin
    mc[0] = c2; mt[0] = t5;
    mc[1] = s2; mt[1] = t4;
    mc[2] = c2; mt[2] = t6;
    mc[3] = s2; mt[3] = t3;
    mc[4] = c2; mt[4] = t4;
    mc[5] = s2; mt[5] = t5;
  end

  always_ff @(posedge clk) begin
    if (e3) begin
      l3 <= l2;
      for (int i = 0; i < 6; i++) begin
        pp_lo[i] <= PLW'(mc[i]) * PLW'(signed'({1'b0, mt[i][LO_W-1:0]}));
        pp_hi[i] <= PHW'(mc[i]) * PHW'(signed'(mt[i][TW-1:LO_W]));
      end
    end
  end

  // Stage 4: merge partial products into exact products
  logic signed [PW-1:0] prod [6];
  logic                 l4;

  always_ff @(posedge clk) begin
    if (e4) begin
      l4 <= l3;
      for (int i = 0; i < 6; i++) begin
        prod[i] <= (PW'(pp_hi[i]) <<< LO_W) + PW'(pp_lo[i]);
      end
    end
  end

  // Stage 5: final sums with the rounding half added
  logic signed [RSW-1:0] xs5, ys5, zs5;
  logic                  l5;

  always_ff @(posedge clk) begin
    if (e5) begin
      l5  <= l4;
      xs5 <= RSW'(prod[0]) + RSW'(prod[1]) + HALF;
      ys5 <= RSW'(prod[2]) - RSW'(prod[3]) + HALF;
      zs5 <= RSW'(prod[4]) - RSW'(prod[5]) + HALF;
    end
  end

  // Stage 6: shift, saturate, output register
  logic signed [DATA_WIDTH-1:0] xo, yo, zo;
  logic                         lo6;

  always_ff @(posedge clk) begin
    if (e6) begin
      xo  <= sat(xs5);
      yo  <= sat(ys5);
      zo  <= sat(zs5);
      lo6 <= l5;
    end
  end

  assign res.valid    = v6;
  assign res.x_out    = xo;
  assign res.y_out    = yo;
  assign res.z_out    = zo;
  assign res.last_out = lo6;

endmodule

// ----- hw/rtl/rot2_checker.sv -----
// rot2_checker: port-level assertions for the rotation core, bound to its top.
// Depends on rot2_pkg and symmetric_2x2_rotation_apply_core.
module rot2_checker #(
  parameter int DATA_WIDTH = rot2_pkg::DATA_WIDTH_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  req_valid,
  input logic                  req_ready,
  input logic                  res_valid,
  input logic                  res_ready,
  input logic [DATA_WIDTH-1:0] res_x,
  input logic                  res_last
);

  // Requests accepted but not yet delivered
  logic [3:0] in_flight;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
    end else begin
      in_flight <= in_flight + 4'(req_valid && req_ready) - 4'(res_valid && res_ready);
    end
  end

  // Output register empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // A result only exists for an accepted request
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> in_flight != 4'd0)
    else $error("result without pending request");

  // Never more requests in flight than pipeline stages
  a_depth: assert property (@(posedge clk) disable iff (rst)
    in_flight <= 4'(rot2_pkg::PIPE_STAGES))
    else $error("more requests in flight than stages");

  // With the output register empty the core must take requests
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> req_ready)
    else $error("request stalled while output is empty");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_x) && $stable(res_last))
    else $error("stalled result changed");

endmodule

bind symmetric_2x2_rotation_apply_core rot2_checker #(
  .DATA_WIDTH(DATA_WIDTH)
) u_rot2_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req.valid),
  .req_ready(req.ready),
  .res_valid(res.valid),
  .res_ready(res.ready),
  .res_x    (res.x_out),
  .res_last (res.last_out)
);
